[src/ldsm_pkg.sv]
// ----------------------------------------------------------------------------
// ldsm_pkg
// Shared constants, types and helpers for the LED matrix / digit scan mux.
// ----------------------------------------------------------------------------
package ldsm_pkg;

  localparam int MATRIX_ROWS       = 4;
  localparam int DIGIT_COUNT       = 2;
  localparam int DIM_FRAMES        = 8;
  localparam int ROW_SELECT_BASE   = 0;
  localparam int DIGIT_SELECT_BASE = 4;

  localparam int PHASE_COUNT = MATRIX_ROWS + DIGIT_COUNT;
  localparam int PHASE_W     = (PHASE_COUNT > 1) ? $clog2(PHASE_COUNT) : 1;
  localparam int FRAME_W     = $clog2(DIM_FRAMES);

  localparam int FUNC_W    = 2;
  localparam int INDEX_W   = 2;
  localparam int BYTE_W    = 8;
  localparam int ROW_W     = 5;
  localparam int SEL_POS_W = 5;

  localparam logic [ROW_W-1:0] ROW_MASK = 5'h1F;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK       = 2'd0,
    FUNC_SET_BRIGHT = 2'd1,
    FUNC_SET_DIM    = 2'd2,
    FUNC_SET_DIGIT  = 2'd3
  } func_t;

  typedef struct packed {
    func_t              func;
    logic [INDEX_W-1:0] index;
    logic [BYTE_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] bus_value;
    logic [BYTE_W-1:0] select_value;
    logic              last;
  } out_item_t;

  // One-hot select byte; a position off the bus gives zero.
  function automatic logic [BYTE_W-1:0] select_onehot(input logic [SEL_POS_W-1:0] pos);
    logic [BYTE_W-1:0] res;
    for (int i = 0; i < BYTE_W; i++) begin
      res[i] = (pos == SEL_POS_W'(i));
    end
    return res;
  endfunction

endpackage

[src/ldsm_if.sv]
// ----------------------------------------------------------------------------
// ldsm_in_if / ldsm_out_if
// Valid/ready channels for scan mux items and results.
// ----------------------------------------------------------------------------
interface ldsm_in_if;
  import ldsm_pkg::*;

  logic               valid;
  logic               ready;
  func_t              func;
  logic [INDEX_W-1:0] index;
  logic [BYTE_W-1:0]  value;

  modport source (output valid, output func, output index, output value, input ready);
  modport sink   (input valid, input func, input index, input value, output ready);
endinterface

interface ldsm_out_if;
  import ldsm_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] bus_value;
  logic [BYTE_W-1:0] select_value;
  logic              last;

  modport source (output valid, output bus_value, output select_value, output last,
                  input ready);
  modport sink   (input valid, input bus_value, input select_value, input last,
                  output ready);
endinterface

[src/ldsm_scan_core.sv]
// ----------------------------------------------------------------------------
// ldsm_scan_core
// Row, dim row and digit storage, scan phase and dim frame counters, and the
// drive word for the current phase.
// ----------------------------------------------------------------------------
module ldsm_scan_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  ldsm_pkg::in_item_t  item,
  output ldsm_pkg::out_item_t drive
);
  import ldsm_pkg::*;

  logic [ROW_W-1:0]   bright_r [MATRIX_ROWS];
  logic [ROW_W-1:0]   dim_r    [MATRIX_ROWS];
  logic [BYTE_W-1:0]  digit_r  [DIGIT_COUNT];
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic               tick;
  logic [BYTE_W-1:0]  bus;
  logic [SEL_POS_W-1:0] pos;
  logic               pos_hit;

  assign tick = take && (item.func == FUNC_TICK);

  // Advance phase; advance dim frame on phase wrap.
  always_comb begin
    phase_nxt = phase_r;
    frame_nxt = frame_r;
    if (tick) begin
      if (phase_r == PHASE_W'(PHASE_COUNT - 1)) begin
        phase_nxt = '0;
        frame_nxt = (frame_r == FRAME_W'(DIM_FRAMES - 1)) ? '0 : frame_r + 1'b1;
      end else begin
        phase_nxt = phase_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      frame_r <= '0;
      for (int i = 0; i < MATRIX_ROWS; i++) begin
        bright_r[i] <= '0;
        dim_r[i]    <= '0;
      end
      for (int d = 0; d < DIGIT_COUNT; d++) begin
        digit_r[d] <= '0;
      end
    end else begin
      phase_r <= phase_nxt;
      frame_r <= frame_nxt;
      if (take) begin
        // Out-of-range indexes match no entry and drop.
        for (int i = 0; i < MATRIX_ROWS; i++) begin
          if (int'(item.index) == i) begin
            if (item.func == FUNC_SET_BRIGHT) bright_r[i] <= item.value[ROW_W-1:0] & ROW_MASK;
            if (item.func == FUNC_SET_DIM)    dim_r[i]    <= item.value[ROW_W-1:0] & ROW_MASK;
          end
        end
        for (int d = 0; d < DIGIT_COUNT; d++) begin
          if (int'(item.index) == d && item.func == FUNC_SET_DIGIT) begin
            digit_r[d] <= item.value;
          end
        end
      end
    end
  end

  // Drive word for the current phase; dim rows light only in frame zero.
  always_comb begin
    bus     = '0;
    pos     = '0;
    pos_hit = 1'b0;
    for (int i = 0; i < MATRIX_ROWS; i++) begin
      if (phase_r == PHASE_W'(i)) begin
        bus     = BYTE_W'(bright_r[i] | ((frame_r == '0) ? dim_r[i] : '0));
        pos     = SEL_POS_W'(ROW_SELECT_BASE + i);
        pos_hit = 1'b1;
      end
    end
    for (int d = 0; d < DIGIT_COUNT; d++) begin
      if (phase_r == PHASE_W'(MATRIX_ROWS + d)) begin
        bus     = digit_r[d];
        pos     = SEL_POS_W'(DIGIT_SELECT_BASE + d);
        pos_hit = 1'b1;
      end
    end
    drive.bus_value    = bus;
    drive.select_value = pos_hit ? select_onehot(pos) : '0;
    drive.last         = 1'b1;
  end

endmodule

[src/led_matrix_digit_scan_mux_top.sv]
// ----------------------------------------------------------------------------
// led_matrix_digit_scan_mux_top
// Six-phase multiplexed scanner for LED matrix rows and seven-segment digits
// sharing one drive bus.
//
//   channel  dir  handshake            payload
//   in_ch    in   valid/ready          func, index, value
//   out_ch   out  valid/ready          bus_value, select_value, last
//
// A write item gives no result; one may follow every cycle while the input
// is not stalled. A tick gives a blanking word then a drive word, both from
// the single result port, so no item is taken while the drive word waits.
// The drive word waits in a one-entry holding register behind
// the result register; input stalls only while that register is full or the
// result register is full and not being taken. Reset (synchronous, low)
// clears all stored rows, digits and counters.
// ----------------------------------------------------------------------------
module led_matrix_digit_scan_mux_top (
  input logic       clk,
  input logic       rst_n,
  ldsm_in_if.sink   in_ch,
  ldsm_out_if.source out_ch
);
  import ldsm_pkg::*;

  in_item_t  item;
  out_item_t drive;
  out_item_t out_r;
  out_item_t drv_r;
  logic      out_valid_r, out_valid_nxt;
  logic      drv_valid_r, drv_valid_nxt;
  logic      in_ready;
  logic      in_take;
  logic      tick_take;
  logic      out_free;

  assign item.func  = in_ch.func;
  assign item.index = in_ch.index;
  assign item.value = in_ch.value;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_ready  = !drv_valid_r && out_free;
  assign in_take   = in_ch.valid && in_ready;
  assign tick_take = in_take && (in_ch.func == FUNC_TICK);

  ldsm_scan_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (in_take),
    .item  (item),
    .drive (drive)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    drv_valid_nxt = drv_valid_r;
    if (out_free) begin
      if (drv_valid_r) begin
        out_valid_nxt = 1'b1;
        drv_valid_nxt = 1'b0;
      end else if (tick_take) begin
        out_valid_nxt = 1'b1;
        drv_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      drv_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      drv_valid_r <= drv_valid_nxt;
    end
  end

  // Payload: blank word goes out first, drive word holds behind it.
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (drv_valid_r) begin
        out_r <= drv_r;
      end else if (tick_take) begin
        out_r <= '{bus_value: '0, select_value: '0, last: 1'b0};
        drv_r <= drive;
      end
    end
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.bus_value    = out_r.bus_value;
  assign out_ch.select_value = out_r.select_value;
  assign out_ch.last         = out_r.last;

endmodule

[src/ldsm_checker.sv]
// ----------------------------------------------------------------------------
// ldsm_checker
// Port-level checks on the scan mux, bound to the top level.
// ----------------------------------------------------------------------------
module ldsm_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input ldsm_pkg::func_t           in_func,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [ldsm_pkg::BYTE_W-1:0] out_bus_value,
  input logic [ldsm_pkg::BYTE_W-1:0] out_select_value,
  input logic                      out_last
);
  import ldsm_pkg::*;

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bus_value)
      && $stable(out_select_value) && $stable(out_last))
    else $error("result changed while stalled");

  // Blanking word drives nothing.
  a_blank_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_bus_value == '0 && out_select_value == '0)
    else $error("blanking word not zero");

  // Drive word follows its blanking word at once.
  a_drive_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_last)
    else $error("drive word did not follow blank");

  // A tick fills both result slots, so the next cycle takes no item.
  a_tick_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func == FUNC_TICK |=> !in_ready)
    else $error("input taken while drive word pending");

  // At most one select line on.
  a_select_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(out_select_value))
    else $error("select not one-hot");

endmodule

bind led_matrix_digit_scan_mux_top ldsm_checker u_ldsm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_func          (in_ch.func),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_bus_value    (out_ch.bus_value),
  .out_select_value (out_ch.select_value),
  .out_last         (out_ch.last)
);

[test/ldsm_scan_checker.sv]
// ----------------------------------------------------------------------------
// ldsm_scan_checker
// Watches both channels of the scan mux. It keeps its own copy of the row,
// dim-row and digit stores and of the scan counters, and checks every result
// word in order against the blank and drive words each tick should give.
// ----------------------------------------------------------------------------
module ldsm_scan_checker (
  input  logic clk,
  input  logic rst_n,
  ldsm_in_if   in_ch,
  ldsm_out_if  out_ch,
  output int   mismatch_count,
  output int   words_waiting,
  output int   words_checked,
  output int   ticks_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import ldsm_pkg::*;

  logic [ROW_W-1:0]   bright_row [MATRIX_ROWS];
  logic [ROW_W-1:0]   dim_row    [MATRIX_ROWS];
  logic [BYTE_W-1:0]  digit_segs [DIGIT_COUNT];
  logic [PHASE_W-1:0] scan_step;
  logic [FRAME_W-1:0] dim_count;

  out_item_t expected_words [$];
  int        fails   = 0;
  int        checked = 0;
  int        ticks   = 0;

  always @(posedge clk) begin : track
    out_item_t        got;
    out_item_t        want;
    out_item_t        drive;
    int               sel_pos;
    logic [ROW_W-1:0] row_bits;

    if (!rst_n) begin
      foreach (bright_row[i]) begin
        bright_row[i] = '0;
        dim_row[i]    = '0;
      end
      foreach (digit_segs[i]) digit_segs[i] = '0;
      scan_step = '0;
      dim_count = '0;
      expected_words.delete();
    end else begin
      // Compare first so that a result can never match the tick of this edge.
      if (out_ch.valid && out_ch.ready) begin
        got.bus_value    = out_ch.bus_value;
        got.select_value = out_ch.select_value;
        got.last         = out_ch.last;
        if (expected_words.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("ERROR %0t: result with nothing expected: bus=%02h sel=%02h last=%0b",
                     $time, got.bus_value, got.select_value, got.last);
          end
        end else begin
          want = expected_words.pop_front();
          checked++;
          if (got.bus_value !== want.bus_value || got.select_value !== want.select_value ||
              got.last !== want.last) begin
            fails++;
            if (fails <= 10) begin
              $display("ERROR %0t: word %0d expected bus/sel/last=%02h/%02h/%0b got %02h/%02h/%0b",
                       $time, checked, want.bus_value, want.select_value, want.last,
                       got.bus_value, got.select_value, got.last);
            end
          end
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.func)
          FUNC_SET_BRIGHT: begin
            if (int'(in_ch.index) < MATRIX_ROWS) bright_row[in_ch.index] = in_ch.value[ROW_W-1:0];
          end
          FUNC_SET_DIM: begin
            if (int'(in_ch.index) < MATRIX_ROWS) dim_row[in_ch.index] = in_ch.value[ROW_W-1:0];
          end
          FUNC_SET_DIGIT: begin
            if (int'(in_ch.index) < DIGIT_COUNT) digit_segs[in_ch.index] = in_ch.value;
          end
          default: begin
            ticks++;
            expected_words.push_back('{bus_value: '0, select_value: '0, last: 1'b0});
            if (int'(scan_step) < MATRIX_ROWS) begin
              row_bits = bright_row[scan_step];
              // OR the dim row in on the first frame of each dim cycle only
              if (dim_count == '0) row_bits |= dim_row[scan_step];
              drive.bus_value = BYTE_W'(row_bits);
              sel_pos         = ROW_SELECT_BASE + int'(scan_step);
            end else begin
              drive.bus_value = digit_segs[int'(scan_step) - MATRIX_ROWS];
              sel_pos         = DIGIT_SELECT_BASE + int'(scan_step) - MATRIX_ROWS;
            end
            drive.select_value = (sel_pos < BYTE_W) ? BYTE_W'(1 << sel_pos) : '0;
            drive.last         = 1'b1;
            expected_words.push_back(drive);
            if (int'(scan_step) == PHASE_COUNT - 1) begin
              scan_step = '0;
              dim_count = (int'(dim_count) == DIM_FRAMES - 1) ? '0 : dim_count + 1'b1;
            end else begin
              scan_step = scan_step + 1'b1;
            end
          end
        endcase
      end
    end

    mismatch_count <= fails;
    words_waiting  <= expected_words.size();
    words_checked  <= checked;
    ticks_seen     <= ticks;
  end

endmodule

[test/led_matrix_digit_scan_mux_top_tb.sv]
// ----------------------------------------------------------------------------
// led_matrix_digit_scan_mux_top_tb
// Drives row, dim-row and digit writes and scan ticks into the scan mux with
// random gaps and back-pressure; a checker beside the block predicts and
// compares every blank and drive word.
// ----------------------------------------------------------------------------
module led_matrix_digit_scan_mux_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ldsm_pkg::*;

  localparam int RANDOM_ITEMS = 900;
  localparam int LONG_HOLD    = 80;
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst_n;
  logic steady;
  logic long_hold_req;
  int   items_sent;
  int   mismatch_count;
  int   words_waiting;
  int   words_checked;
  int   ticks_seen;

  ldsm_in_if  in_ch ();
  ldsm_out_if out_ch ();

  led_matrix_digit_scan_mux_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ldsm_scan_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (mismatch_count),
    .words_waiting  (words_waiting),
    .words_checked  (words_checked),
    .ticks_seen     (ticks_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly no gap, some short, a few long.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input func_t f, input logic [INDEX_W-1:0] idx,
                           input logic [BYTE_W-1:0] val);
    int gap;
    gap = steady ? 0 : idle_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= f;
    in_ch.index <= idx;
    in_ch.value <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid so the last item is not transferred again while draining.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (words_waiting != 0);
  endtask

  // Result side: random stalls, plus one long counted hold on request.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req <= 1'b0;
        out_ch.ready  <= 1'b1;
        @(posedge clk);
      end else if (!steady && idle_gap() > 0) begin
        out_ch.ready <= 1'b0;
        repeat (idle_gap() + 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    #6ms;
    $display("ERROR: run timed out with %0d result words outstanding", words_waiting);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    func_t f;
    rst_n         <= 1'b0;
    steady        <= 1'b0;
    long_hold_req <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.func    <= FUNC_TICK;
    in_ch.index   <= '0;
    in_ch.value   <= '0;
    items_sent    = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: upper bits dropped on rows, ignored digit slots, all phases.
    send_item(FUNC_TICK,       2'd3, 8'hFF);
    send_item(FUNC_SET_BRIGHT, 2'd0, 8'hFF);
    send_item(FUNC_SET_BRIGHT, 2'd1, 8'hE0);
    send_item(FUNC_SET_BRIGHT, 2'd2, 8'h15);
    send_item(FUNC_SET_BRIGHT, 2'd3, 8'h0A);
    send_item(FUNC_SET_DIM,    2'd0, 8'h00);
    send_item(FUNC_SET_DIM,    2'd1, 8'hFF);
    send_item(FUNC_SET_DIM,    2'd2, 8'h0A);
    send_item(FUNC_SET_DIM,    2'd3, 8'hF5);
    send_item(FUNC_SET_DIGIT,  2'd0, 8'hFF);
    send_item(FUNC_SET_DIGIT,  2'd1, 8'h80);
    send_item(FUNC_SET_DIGIT,  2'd2, 8'h55);
    send_item(FUNC_SET_DIGIT,  2'd3, 8'hAA);
    for (int k = 0; k < 7; k++) send_item(FUNC_TICK, 2'(k), 8'(k * 37));
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 150) steady <= 1'b1;
      if (i == 300) steady <= 1'b0;
      // Hold the result side off while ticks keep coming, so the input stalls.
      if (i == 400) begin
        steady        <= 1'b1;
        long_hold_req <= 1'b1;
      end
      if (i == 460) steady <= 1'b0;
      if (i == 650) wait_drained();
      f = func_t'($urandom_range(0, 3));
      if ($urandom_range(0, 1) == 1) f = FUNC_TICK;
      send_item(f, INDEX_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)));
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d items transferred in, %0d result words checked.",
             items_sent, words_checked);
    $display("Summary: %0d ticks, %0d full scans, %0d mismatches.",
             ticks_seen, ticks_seen / PHASE_COUNT, mismatch_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
